>>> hw/rtl/p2ba_pkg.sv
// ----------------------------------------------------------------------------
// p2ba_pkg: shared types and word functions of the region allocator
// Request kinds, response status codes and the per-word search helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package p2ba_pkg;

  localparam int WordW = 32;

  typedef enum logic [1:0] {
    KIND_FIND  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_TAKEN = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  localparam logic [WordW-1:0] FoldMask1 = 32'haaaaaaaa;
  localparam logic [WordW-1:0] FoldMask2 = 32'h88888888;
  localparam logic [WordW-1:0] FoldMask4 = 32'h80808080;
  localparam logic [WordW-1:0] FoldMask8 = 32'h80008000;
  localparam logic [WordW-1:0] WordOnes  = 32'hffffffff;

  // Marks the first bit of every aligned, fully free group of 2^s bits.
  // Bit 31 is the lowest index, so each group is marked at its top bit.
  function automatic logic [WordW-1:0] word_fit(input logic [WordW-1:0] w,
                                                input logic [2:0] s);
    logic [WordW-1:0] f1, f2, f4, f8, r;
    f1 = w & (w << 1) & FoldMask1;
    f2 = f1 & (f1 << 2) & FoldMask2;
    f4 = f2 & (f2 << 4) & FoldMask4;
    f8 = f4 & (f4 << 8) & FoldMask8;
    case (s)
      3'd0:    r = w;
      3'd1:    r = f1;
      3'd2:    r = f2;
      3'd3:    r = f4;
      3'd4:    r = f8;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Position, counted from the top bit, of the highest set bit.
  function automatic logic [4:0] first_one(input logic [WordW-1:0] v);
    logic [4:0] pos;
    pos = '0;
    for (int i = 0; i < WordW; i++) begin
      if (v[i]) begin
        pos = 5'(WordW - 1 - i);
      end
    end
    return pos;
  endfunction

  // Mask of a region of 2^s bits that starts at offset off within a word.
  function automatic logic [WordW-1:0] small_mask(input logic [2:0] s,
                                                  input logic [4:0] off);
    logic [5:0] len;
    len = 6'd1 << s;
    return (~(WordOnes >> len)) >> off;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/p2ba_stream_if.sv
// ----------------------------------------------------------------------------
// p2ba_stream_if: request and response channels of the region allocator
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface p2ba_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] size_shift;
  logic [7:0] index;

  modport source (output valid, output kind, output size_shift, output index,
                  input ready);
  modport sink (input valid, input kind, input size_shift, input index,
                output ready);
endinterface

interface p2ba_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] result_index;
  logic       map_empty;

  modport source (output valid, output status, output result_index,
                  output map_empty, input ready);
  modport sink (input valid, input status, input result_index,
                input map_empty, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pow2_bitmap_region_allocator.sv
// ----------------------------------------------------------------------------
// pow2_bitmap_region_allocator: first-fit bitmap allocator, power-of-two regions
// Keeps a free map in a word memory and serves find, allocate and free requests.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Transfer                Payload
//  req_i    in   valid & ready           kind, size_shift, index
//  rsp_o    out  valid & ready           status, result_index, map_empty
//
//  A request is taken only while the sequencer is idle; the response register
//  lets the next request in while an earlier response still waits.
//  The map words are read one per cycle through the registered memory port: a
//  find reads up to NUM_BITS/32 words (rounded up to a whole group for large
//  sizes), and a large find, allocate or free then writes 2^size_shift/32 words.
//  Reset needs no clearing pass; per-word valid flags make the map read free.
//  A stalled response holds the sequencer in its final state.
//
`default_nettype none

module pow2_bitmap_region_allocator #(
  parameter int NUM_BITS = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  p2ba_req_if.sink   req_i,
  p2ba_rsp_if.source rsp_o
);
  import p2ba_pkg::*;

  localparam int NW = NUM_BITS / 32;
  localparam int TW = $clog2(2 * NW);
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int SW = $clog2(NUM_BITS) + 1;
  localparam int CW = $clog2(NUM_BITS + 1);
  localparam logic [TW-1:0] NwT   = TW'(NW);
  localparam logic [TW-1:0] LastW = TW'(NW - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_FIN
  } state_e;

  // Scan positions run past the last word when a large group wraps round.
  function automatic logic [AW-1:0] word_addr(input logic [TW-1:0] t);
    logic [TW-1:0] a;
    a = (t >= NwT) ? (t - NwT) : t;
    return AW'(a);
  endfunction

  // Free map storage
  logic [WordW-1:0] map_q [NW];
  logic [NW-1:0]    valid_q, valid_d;
  logic [WordW-1:0] rd_data_q;
  logic             rd_vld_q;
  logic             mem_we;
  logic [AW-1:0]    mem_wa, rd_addr;
  logic [WordW-1:0] mem_wd;

  // Sequencer registers
  state_e        state_q, state_d;
  logic [1:0]    kind_q, kind_d;
  logic [2:0]    shift_q, shift_d;
  logic          large_q, large_d;
  logic [7:0]    idx_q, idx_d;
  logic [TW-1:0] kmask_q, kmask_d;
  logic [TW-1:0] tlast_q, tlast_d;
  logic [TW-1:0] rt_q, rt_d;
  logic [TW-1:0] et_q, et_d;
  logic [TW-1:0] wt_q, wt_d;
  logic [TW-1:0] wend_q, wend_d;
  logic          rmore_q, rmore_d;
  logic          ev_q, ev_d;
  logic          grp_q, grp_d;
  logic [SW-1:0] sz_q, sz_d;
  logic [CW-1:0] used_q, used_d;
  status_e       res_status_q, res_status_d;
  logic [7:0]    res_idx_q, res_idx_d;
  logic          res_empty_q, res_empty_d;
  logic          out_valid_q, out_valid_d;
  status_e       out_status_q, out_status_d;
  logic [7:0]    out_idx_q, out_idx_d;
  logic          out_empty_q, out_empty_d;

  // Request decode
  logic [16:0]   size_w, km_w;
  logic          sz_bad, place_bad, kind_bad, req_bad, req_large;
  logic [TW-1:0] kmask_in, tstart_in, tlast_in;

  always_comb begin
    size_w    = 17'd1 << req_i.size_shift;
    sz_bad    = size_w > 17'(NUM_BITS);
    place_bad = ((17'(req_i.index) & (size_w - 17'd1)) != 17'd0) ||
                ((17'(req_i.index) + size_w) > 17'(NUM_BITS));
    kind_bad  = (req_i.kind != KIND_FIND) && (req_i.kind != KIND_ALLOC) &&
                (req_i.kind != KIND_FREE);
    req_bad   = kind_bad || sz_bad || ((req_i.kind != KIND_FIND) && place_bad);
    req_large = req_i.size_shift >= 4'd5;
    km_w      = req_large ? ((size_w >> 5) - 17'd1) : 17'd0;
    kmask_in  = TW'(km_w);
    tstart_in = (req_i.kind == KIND_FIND) ? '0 : TW'(req_i.index >> 5);
    tlast_in  = (req_i.kind == KIND_FIND) ? (LastW | kmask_in)
                                          : (tstart_in | kmask_in);
  end

  // Shared word evaluator
  logic [WordW-1:0] word, fit, smask, fmask;
  logic [4:0]       lz;
  logic             found_s, small_ok, word_ok, cur_ok;
  logic [TW-1:0]    off, gstart;
  logic [15:0]      ri_small, ri_large;

  always_comb begin
    word     = rd_vld_q ? rd_data_q : WordOnes;
    fit      = word_fit(word, shift_q);
    found_s  = |fit;
    lz       = first_one(fit);
    fmask    = small_mask(shift_q, lz);
    smask    = small_mask(shift_q, idx_q[4:0]);
    small_ok = (kind_q == KIND_FREE) ? ((word & smask) == '0)
                                     : ((word & smask) == smask);
    word_ok  = (kind_q == KIND_FREE) ? (word == '0) : (word == WordOnes);
    off      = et_q & kmask_q;
    cur_ok   = ((off == '0) ? 1'b1 : grp_q) & word_ok;
    gstart   = et_q & ~kmask_q;
    ri_small = (16'(et_q) << 5) | 16'(lz);
    ri_large = 16'(gstart) << 5;
  end

  assign rd_addr = word_addr(rt_q);

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    shift_d      = shift_q;
    large_d      = large_q;
    idx_d        = idx_q;
    kmask_d      = kmask_q;
    tlast_d      = tlast_q;
    rt_d         = rt_q;
    et_d         = rt_q;
    wt_d         = wt_q;
    wend_d       = wend_q;
    rmore_d      = rmore_q;
    grp_d        = grp_q;
    sz_d         = sz_q;
    used_d       = used_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_empty_d  = res_empty_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_empty_d  = out_empty_q;
    valid_d      = valid_q;
    mem_we       = 1'b0;
    mem_wa       = word_addr(et_q);
    mem_wd       = word;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d       = req_i.kind;
          shift_d      = req_i.size_shift[2:0];
          large_d      = req_large;
          idx_d        = req_i.index;
          kmask_d      = kmask_in;
          tlast_d      = tlast_in;
          rt_d         = tstart_in;
          rmore_d      = 1'b1;
          sz_d         = size_w[SW-1:0];
          res_idx_d    = (req_i.kind == KIND_FIND) ? 8'd0 : req_i.index;
          res_empty_d  = 1'b0;
          res_status_d = ST_BAD;
          state_d      = req_bad ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rmore_q) begin
          if (rt_q == tlast_q) begin
            rmore_d = 1'b0;
          end else begin
            rt_d = rt_q + 1'b1;
          end
        end
        if (ev_q) begin
          grp_d = cur_ok;
          if (!large_q) begin
            if (kind_q == KIND_FIND) begin
              if (found_s) begin
                mem_we       = 1'b1;
                mem_wd       = word & ~fmask;
                used_d       = used_q + CW'(sz_q);
                res_idx_d    = ri_small[7:0];
                res_status_d = ST_OK;
                state_d      = S_FIN;
              end else if (et_q == tlast_q) begin
                res_status_d = ST_NOFIT;
                state_d      = S_FIN;
              end
            end else begin
              if (small_ok) begin
                mem_we       = 1'b1;
                res_status_d = ST_OK;
                if (kind_q == KIND_FREE) begin
                  mem_wd      = word | smask;
                  used_d      = used_q - CW'(sz_q);
                  res_empty_d = (used_q - CW'(sz_q)) == '0;
                end else begin
                  mem_wd = word & ~smask;
                  used_d = used_q + CW'(sz_q);
                end
              end else begin
                res_status_d = (kind_q == KIND_ALLOC) ? ST_TAKEN : ST_BAD;
              end
              state_d = S_FIN;
            end
          end else if (off == kmask_q) begin
            if (cur_ok) begin
              wt_d   = gstart;
              wend_d = et_q;
              if (kind_q == KIND_FIND) begin
                res_idx_d = ri_large[7:0];
              end
              state_d = S_WRITE;
            end else if ((kind_q == KIND_FIND) && (et_q != tlast_q)) begin
              state_d = S_SCAN;
            end else begin
              case (kind_q)
                KIND_FIND:  res_status_d = ST_NOFIT;
                KIND_ALLOC: res_status_d = ST_TAKEN;
                default:    res_status_d = ST_BAD;
              endcase
              state_d = S_FIN;
            end
          end
        end
      end
      S_WRITE: begin
        mem_we = 1'b1;
        mem_wa = word_addr(wt_q);
        mem_wd = (kind_q == KIND_FREE) ? WordOnes : '0;
        if (wt_q == wend_q) begin
          res_status_d = ST_OK;
          if (kind_q == KIND_FREE) begin
            used_d      = used_q - CW'(sz_q);
            res_empty_d = (used_q - CW'(sz_q)) == '0;
          end else begin
            used_d = used_q + CW'(sz_q);
          end
          state_d = S_FIN;
        end else begin
          wt_d = wt_q + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = res_idx_q;
          out_empty_d  = res_empty_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (mem_we) begin
      valid_d[mem_wa] = 1'b1;
    end
    // Words still in flight are dropped once the scan has reached a decision.
    ev_d = (state_q == S_SCAN) && rmore_q && (state_d == S_SCAN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= '0;
      shift_q      <= '0;
      large_q      <= 1'b0;
      idx_q        <= '0;
      kmask_q      <= '0;
      tlast_q      <= '0;
      rt_q         <= '0;
      et_q         <= '0;
      wt_q         <= '0;
      wend_q       <= '0;
      rmore_q      <= 1'b0;
      ev_q         <= 1'b0;
      grp_q        <= 1'b0;
      sz_q         <= '0;
      used_q       <= '0;
      res_status_q <= ST_OK;
      res_idx_q    <= '0;
      res_empty_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_idx_q    <= '0;
      out_empty_q  <= 1'b0;
      valid_q      <= '0;
      rd_vld_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      shift_q      <= shift_d;
      large_q      <= large_d;
      idx_q        <= idx_d;
      kmask_q      <= kmask_d;
      tlast_q      <= tlast_d;
      rt_q         <= rt_d;
      et_q         <= et_d;
      wt_q         <= wt_d;
      wend_q       <= wend_d;
      rmore_q      <= rmore_d;
      ev_q         <= ev_d;
      grp_q        <= grp_d;
      sz_q         <= sz_d;
      used_q       <= used_d;
      res_status_q <= res_status_d;
      res_idx_q    <= res_idx_d;
      res_empty_q  <= res_empty_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_idx_q    <= out_idx_d;
      out_empty_q  <= out_empty_d;
      valid_q      <= valid_d;
      rd_vld_q     <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= map_q[rd_addr];
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.result_index = out_idx_q;
  assign rsp_o.map_empty    = out_empty_q;

`ifndef SYNTHESIS
  a_empty_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.map_empty |-> rsp_o.status == ST_OK)
    else $error("map_empty reported on a failed request");

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(NUM_BITS))
    else $error("allocated bit count exceeds the map size");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> rt_q <= tlast_q)
    else $error("scan read pointer ran past the last word");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q != S_IDLE && state_q != S_FIN)
    else $error("map written outside a scan or write pass");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("second request taken while the first is in progress");
`endif

endmodule

`default_nettype wire
